### design/mpq_pkg.sv
// Shared types and constants for the max priority queue unit.
// Holds opcode, status, state and cell command encodings and the entry struct.
// No dependencies.
package mpq_pkg;

   localparam int VALUE_W     = 32;
   localparam int PRI_W       = 32;
   localparam int OP_W        = 2;
   localparam int STATUS_W    = 2;
   localparam int REQ_TDATA_W = 72;

   typedef enum logic [OP_W-1:0] {
      OP_INSERT  = 2'd0,
      OP_FIND    = 2'd1,
      OP_EXTRACT = 2'd2,
      OP_MODIFY  = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_EMPTY     = 2'd1,
      STATUS_FULL      = 2'd2,
      STATUS_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SEARCH,
      S_PLACE,
      S_REPLY
   } state_type;

   typedef enum logic [1:0] {
      CMD_HOLD,
      CMD_PLACE,
      CMD_SHIFT
   } cmd_kind_type;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic [PRI_W-1:0]   pri;
   } entry_type;

   // Command broadcast to every cell; entry doubles as the search key
   typedef struct packed {
      cmd_kind_type kind;
      logic         age_adjust;
      entry_type    entry;
   } cmd_type;

endpackage

### design/mpq_cell.sv
// One slot of the sorted queue row: entry, insertion rank and valid bit.
// Also one stage of the match token that walks the row one cell per cycle.
// Depends on mpq_pkg.
module mpq_cell #(
   parameter int AW    = 4,
   parameter int INDEX = 0
) (
   input  logic                clock,
   input  logic                reset,
   input  mpq_pkg::cmd_type    cmd,
   input  logic [AW-1:0]       cmd_index,
   input  logic [AW-1:0]       cmd_age,
   input  logic                left_valid,
   input  mpq_pkg::entry_type  left_entry,
   input  logic [AW-1:0]       left_age,
   input  logic                left_before,
   input  logic                right_valid,
   input  mpq_pkg::entry_type  right_entry,
   input  logic [AW-1:0]       right_age,
   input  logic                tok_in_valid,
   input  logic                tok_in_found,
   input  logic [AW-1:0]       tok_in_age,
   input  logic [AW-1:0]       tok_in_index,
   output logic                slot_valid,
   output mpq_pkg::entry_type  slot_entry,
   output logic [AW-1:0]       slot_age,
   output logic                ahead,
   output logic                tok_out_valid,
   output logic                tok_out_found,
   output logic [AW-1:0]       tok_out_age,
   output logic [AW-1:0]       tok_out_index
);

   localparam logic [AW-1:0] MY_INDEX = AW'(INDEX);

   logic                valid_ff, valid_in;
   mpq_pkg::entry_type  entry_ff, entry_in;
   logic [AW-1:0]       age_ff, age_in;
   logic                tok_valid_ff, tok_valid_in;
   logic                tok_found_ff, tok_found_in;
   logic [AW-1:0]       tok_age_ff, tok_age_in;
   logic [AW-1:0]       tok_index_ff, tok_index_in;
   logic                hit;

   // New entry goes ahead of this slot when it ranks higher, or the slot is free
   assign ahead = !valid_ff
                  || (cmd.entry.pri > entry_ff.pri)
                  || ((cmd.entry.pri == entry_ff.pri) && (cmd_age > age_ff));

   always_comb begin
      logic [AW-1:0] age_sel;
      valid_in = valid_ff;
      entry_in = entry_ff;
      age_sel  = age_ff;
      case (cmd.kind)
         mpq_pkg::CMD_PLACE: begin
            if (ahead) begin
               if (left_before) begin
                  valid_in = left_valid;
                  entry_in = left_entry;
                  age_sel  = left_age;
               end else begin
                  valid_in = 1'b1;
                  entry_in = cmd.entry;
                  age_sel  = cmd_age;
               end
            end
         end
         mpq_pkg::CMD_SHIFT: begin
            if (MY_INDEX >= cmd_index) begin
               valid_in = right_valid;
               entry_in = right_entry;
               age_sel  = right_age;
            end
         end
         default: ;
      endcase
      // close the gap in insertion ranks left by the removed head
      age_in = age_sel;
      if (cmd.kind == mpq_pkg::CMD_SHIFT && cmd.age_adjust && age_sel > cmd_age) begin
         age_in = age_sel - AW'(1);
      end
   end

   assign hit = tok_in_valid && valid_ff && (entry_ff.value == cmd.entry.value)
                && (!tok_in_found || (age_ff > tok_in_age));

   always_comb begin
      tok_valid_in = tok_in_valid;
      tok_found_in = tok_in_found || hit;
      tok_age_in   = hit ? age_ff : tok_in_age;
      tok_index_in = hit ? MY_INDEX : tok_in_index;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= 1'b0;
         tok_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         tok_valid_ff <= tok_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff     <= entry_in;
      age_ff       <= age_in;
      tok_found_ff <= tok_found_in;
      tok_age_ff   <= tok_age_in;
      tok_index_ff <= tok_index_in;
   end

   assign slot_valid    = valid_ff;
   assign slot_entry    = entry_ff;
   assign slot_age      = age_ff;
   assign tok_out_valid = tok_valid_ff;
   assign tok_out_found = tok_found_ff;
   assign tok_out_age   = tok_age_ff;
   assign tok_out_index = tok_index_ff;

endmodule

### design/max_priority_queue_unit.sv
// Max priority queue: a row of CAPACITY cells kept sorted by priority, newest first on ties.
// Insert, find max and extract max pass from idle straight to reply; modify key walks the
// match token along the cell row one cell per cycle in the search state, then, when a value
// matches, pulls the entry out and places it again in the place state before the reply
// (an empty queue goes straight to reply with not found).
// A response beat held by the receiver stalls the next request beat.
// Synchronous reset empties the queue at once and drops any pending response.
// Depends on mpq_pkg and mpq_cell.
module max_priority_queue_unit #(
   parameter int CAPACITY = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // operation[1:0], element_value[33:2], new_priority[65:34], zero pad
   input  logic [mpq_pkg::REQ_TDATA_W-1:0]        req_tdata,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // result_value[31:0], result_priority[63:32], status[65:64], entry_total, zero pad
   output logic [(((66 + $clog2(CAPACITY + 1)) + 7) / 8) * 8 - 1:0] rsp_tdata
);

   localparam int AW       = $clog2(CAPACITY);
   localparam int CW       = $clog2(CAPACITY + 1);
   localparam int RSP_BITS = mpq_pkg::VALUE_W + mpq_pkg::PRI_W + mpq_pkg::STATUS_W + CW;
   localparam int RSP_W    = ((RSP_BITS + 7) / 8) * 8;
   localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);

   mpq_pkg::state_type    state_ff, state_in;
   logic [CW-1:0]         occ_ff, occ_in;
   mpq_pkg::entry_type    req_ff, req_in;
   logic [AW-1:0]         match_age_ff, match_age_in;
   mpq_pkg::entry_type    pend_ff, pend_in;
   mpq_pkg::status_type   pend_status_ff, pend_status_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]      rsp_data_ff, rsp_data_in;

   mpq_pkg::op_type       req_op;
   mpq_pkg::entry_type    req_entry;
   mpq_pkg::cmd_type      cmd;
   logic [AW-1:0]         cmd_index;
   logic [AW-1:0]         cmd_age;
   logic                  tok_start;
   logic                  accept;
   logic                  rsp_load;

   logic                  slot_valid  [CAPACITY];
   mpq_pkg::entry_type    slot_entry  [CAPACITY];
   logic [AW-1:0]         slot_age    [CAPACITY];
   logic                  slot_before [CAPACITY];
   logic                  tok_valid   [CAPACITY];
   logic                  tok_found   [CAPACITY];
   logic [AW-1:0]         tok_age     [CAPACITY];
   logic [AW-1:0]         tok_index   [CAPACITY];

   assign req_op          = mpq_pkg::op_type'(req_tdata[1:0]);
   assign req_entry.value = req_tdata[33:2];
   assign req_entry.pri   = req_tdata[65:34];
   assign accept          = req_tvalid && req_tready;

   always_comb begin
      state_in       = state_ff;
      occ_in         = occ_ff;
      req_in         = req_ff;
      match_age_in   = match_age_ff;
      pend_in        = pend_ff;
      pend_status_in = pend_status_ff;
      cmd.kind       = mpq_pkg::CMD_HOLD;
      cmd.age_adjust = 1'b0;
      cmd.entry      = req_ff;
      cmd_index      = '0;
      cmd_age        = '0;
      tok_start      = 1'b0;
      req_tready     = 1'b0;
      rsp_load       = 1'b0;
      unique case (state_ff)
         mpq_pkg::S_IDLE: begin
            req_tready = 1'b1;
            cmd.entry  = req_entry;
            if (req_tvalid) begin
               req_in         = req_entry;
               pend_in        = '0;
               pend_status_in = mpq_pkg::STATUS_OK;
               state_in       = mpq_pkg::S_REPLY;
               unique case (req_op)
                  mpq_pkg::OP_INSERT: begin
                     if (occ_ff == FULL_COUNT) begin
                        pend_status_in = mpq_pkg::STATUS_FULL;
                     end else begin
                        cmd.kind = mpq_pkg::CMD_PLACE;
                        cmd_age  = occ_ff[AW-1:0];
                        occ_in   = occ_ff + CW'(1);
                     end
                  end
                  mpq_pkg::OP_FIND, mpq_pkg::OP_EXTRACT: begin
                     if (occ_ff == '0) begin
                        pend_status_in = mpq_pkg::STATUS_EMPTY;
                     end else begin
                        pend_in = slot_entry[0];
                        if (req_op == mpq_pkg::OP_EXTRACT) begin
                           // drop the head, pull the row up, renumber younger ranks
                           cmd.kind       = mpq_pkg::CMD_SHIFT;
                           cmd.age_adjust = 1'b1;
                           cmd_age        = slot_age[0];
                           occ_in         = occ_ff - CW'(1);
                        end
                     end
                  end
                  mpq_pkg::OP_MODIFY: begin
                     if (occ_ff == '0) begin
                        pend_status_in = mpq_pkg::STATUS_NOT_FOUND;
                     end else begin
                        tok_start = 1'b1;
                        state_in  = mpq_pkg::S_SEARCH;
                     end
                  end
               endcase
            end
         end
         mpq_pkg::S_SEARCH: begin
            if (tok_valid[CAPACITY-1]) begin
               if (tok_found[CAPACITY-1]) begin
                  // pull the matched entry out; it goes back in at its new place
                  cmd.kind     = mpq_pkg::CMD_SHIFT;
                  cmd_index    = tok_index[CAPACITY-1];
                  match_age_in = tok_age[CAPACITY-1];
                  state_in     = mpq_pkg::S_PLACE;
               end else begin
                  pend_status_in = mpq_pkg::STATUS_NOT_FOUND;
                  state_in       = mpq_pkg::S_REPLY;
               end
            end
         end
         mpq_pkg::S_PLACE: begin
            cmd.kind = mpq_pkg::CMD_PLACE;
            cmd_age  = match_age_ff;
            state_in = mpq_pkg::S_REPLY;
         end
         mpq_pkg::S_REPLY: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = mpq_pkg::S_IDLE;
            end
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = RSP_W'({occ_ff, pend_status_ff, pend_ff.pri, pend_ff.value});
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mpq_pkg::S_IDLE;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff         <= req_in;
      match_age_ff   <= match_age_in;
      pend_ff        <= pend_in;
      pend_status_ff <= pend_status_in;
      rsp_data_ff    <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic                lv, lb, rv, tv, tf;
      mpq_pkg::entry_type  le, re;
      logic [AW-1:0]       la, ra, ta, ti;

      if (i == 0) begin : g_head
         assign lv = 1'b0;
         assign le = '0;
         assign la = '0;
         assign lb = 1'b0;
         assign tv = tok_start;
         assign tf = 1'b0;
         assign ta = '0;
         assign ti = '0;
      end else begin : g_body
         assign lv = slot_valid[i-1];
         assign le = slot_entry[i-1];
         assign la = slot_age[i-1];
         assign lb = slot_before[i-1];
         assign tv = tok_valid[i-1];
         assign tf = tok_found[i-1];
         assign ta = tok_age[i-1];
         assign ti = tok_index[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign rv = 1'b0;
         assign re = '0;
         assign ra = '0;
      end else begin : g_inner
         assign rv = slot_valid[i+1];
         assign re = slot_entry[i+1];
         assign ra = slot_age[i+1];
      end

      mpq_cell #(
         .AW    (AW),
         .INDEX (i)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .cmd           (cmd),
         .cmd_index     (cmd_index),
         .cmd_age       (cmd_age),
         .left_valid    (lv),
         .left_entry    (le),
         .left_age      (la),
         .left_before   (lb),
         .right_valid   (rv),
         .right_entry   (re),
         .right_age     (ra),
         .tok_in_valid  (tv),
         .tok_in_found  (tf),
         .tok_in_age    (ta),
         .tok_in_index  (ti),
         .slot_valid    (slot_valid[i]),
         .slot_entry    (slot_entry[i]),
         .slot_age      (slot_age[i]),
         .ahead         (slot_before[i]),
         .tok_out_valid (tok_valid[i]),
         .tok_out_found (tok_found[i]),
         .tok_out_age   (tok_age[i]),
         .tok_out_index (tok_index[i])
      );
   end

endmodule
